// File: design/tccur_pkg.sv
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tccur_pkg;

  // Fixed field widths of the cell coordinates
  localparam int COL_W = 7;
  localparam int ROW_W = 5;

  // Tab stops fall on multiples of 2**TAB_BITS
  localparam int TAB_BITS = 3;

  localparam logic [31:0] DEFAULT_FG = 32'h00FF_FFFF;

  // Character codes with special handling
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  // Input opcodes
  localparam logic OP_PUT   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result actions
  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_DRAW   = 2'd1,
    ACT_SCROLL = 2'd2
  } action_t;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_NL,
    CMD_CR,
    CMD_BS,
    CMD_TAB,
    CMD_PRINT,
    CMD_DROP
  } cmd_kind_t;

  // One queued command from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic        need_clear;
    logic [7:0]  char_code;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLR,
    ST_RUN,
    ST_SCROLL
  } back_state_t;

endpackage

// File: design/text_console_cursor_engine.sv
// Top level of the text console cursor engine.
//
//   port group | dir | flow control   | beat contents
//   in_*       | in  | valid / ready  | opcode, char_code
//   out_*      | out | valid / ready  | action, cell_col, cell_row, glyph, colour, last
//   cfg_*      | in  | write enable   | fg_colour value
//
// A printable character passes through the back-end sequencer as a command pop and a draw;
// the first character after reset adds a clear, a wrap at the bottom row adds a scroll,
// and a tab draws a space in each padding cell, 1 to 8 of them, up to the next tab stop.
// A 2-entry command queue lets the front accept beats while the back end works.
// Reset (rst_n low, synchronous) homes the cursor and restores the default colour.
// A stalled out_ready holds the current result; the queue then fills and in_ready drops.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
  parameter int COLS = 80,
  parameter int ROWS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [7:0]                    in_char_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_action,
  output logic [tccur_pkg::COL_W-1:0]   out_cell_col,
  output logic [tccur_pkg::ROW_W-1:0]   out_cell_row,
  output logic [7:0]                    out_glyph,
  output logic [31:0]                   out_colour,
  output logic                          out_last,
  input  logic                          cfg_wr_en,
  input  logic [31:0]                   cfg_wr_data
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  tccur_pkg::cmd_t push_data, pop_data;
  logic [31:0]     fg_colour_r, fg_colour_nxt;

  // Colour register: zero selects the default
  always_comb begin
    fg_colour_nxt = fg_colour_r;
    if (cfg_wr_en) fg_colour_nxt = (cfg_wr_data == '0) ? tccur_pkg::DEFAULT_FG : cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fg_colour_r <= tccur_pkg::DEFAULT_FG;
    else fg_colour_r <= fg_colour_nxt;
  end

  tccur_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_char_code (in_char_code),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  tccur_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tccur_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .fg_colour    (fg_colour_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_cell_col (out_cell_col),
    .out_cell_row (out_cell_row),
    .out_glyph    (out_glyph),
    .out_colour   (out_colour),
    .out_last     (out_last)
  );

  // Clear and scroll beats carry an all-zero cell payload
  a_nondraw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != tccur_pkg::ACT_DRAW) |->
      (out_cell_col == '0) && (out_cell_row == '0) && (out_glyph == '0) &&
      (out_colour == '0))
    else $error("non-draw beat with nonzero payload");

  // Drawn cells stay on screen
  a_draw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == tccur_pkg::ACT_DRAW) |->
      (32'(out_cell_col) < COLS) && (32'(out_cell_row) < ROWS))
    else $error("draw outside the screen");

  // The stored colour is never zero
  a_draw_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == tccur_pkg::ACT_DRAW) |-> (out_colour != '0))
    else $error("draw with zero colour");

  // A scroll always ends its item
  a_scroll_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == tccur_pkg::ACT_SCROLL) |-> out_last)
    else $error("scroll beat not marked last");

endmodule

// File: design/tccur_front.sv
// Front end: accepts input beats, classifies them, tracks first-character clear.
`timescale 1ns / 1ps

module tccur_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [7:0]        in_char_code,
  output logic              push_valid,
  input  logic              push_ready,
  output tccur_pkg::cmd_t   push_data
);

  logic initialized_r;
  logic initialized_nxt;
  logic accept;
  tccur_pkg::cmd_kind_t kind;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Classify the byte
  always_comb begin
    if (in_opcode == tccur_pkg::OP_CLEAR) begin
      kind = tccur_pkg::CMD_CLEAR;
    end else begin
      case (in_char_code)
        tccur_pkg::CHAR_LF:  kind = tccur_pkg::CMD_NL;
        tccur_pkg::CHAR_CR:  kind = tccur_pkg::CMD_CR;
        tccur_pkg::CHAR_BS:  kind = tccur_pkg::CMD_BS;
        tccur_pkg::CHAR_TAB: kind = tccur_pkg::CMD_TAB;
        default: begin
          if (in_char_code >= tccur_pkg::SPACE_CODE) kind = tccur_pkg::CMD_PRINT;
          else kind = tccur_pkg::CMD_DROP;
        end
      endcase
    end
  end

  // A clear command does not count as the first character
  assign push_data.kind       = kind;
  assign push_data.need_clear = (in_opcode == tccur_pkg::OP_PUT) && !initialized_r;
  assign push_data.char_code  = in_char_code;

  always_comb begin
    initialized_nxt = initialized_r;
    if (accept && (in_opcode == tccur_pkg::OP_PUT)) initialized_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initialized_r <= 1'b0;
    end else begin
      initialized_r <= initialized_nxt;
    end
  end

endmodule

// File: design/tccur_queue.sv
// Two-entry command queue between front and back.
`timescale 1ns / 1ps

module tccur_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  tccur_pkg::cmd_t   push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tccur_pkg::cmd_t   pop_data
);

  tccur_pkg::cmd_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r,  count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/tccur_back.sv
// Back end: cursor state, command sequencer and output register.
`timescale 1ns / 1ps

module tccur_back #(
  parameter int COLS = 80,
  parameter int ROWS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  tccur_pkg::cmd_t               pop_data,
  input  logic [31:0]                   fg_colour,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_action,
  output logic [tccur_pkg::COL_W-1:0]   out_cell_col,
  output logic [tccur_pkg::ROW_W-1:0]   out_cell_row,
  output logic [7:0]                    out_glyph,
  output logic [31:0]                   out_colour,
  output logic                          out_last
);

  localparam logic [tccur_pkg::COL_W-1:0] LAST_COL = tccur_pkg::COL_W'(COLS - 1);
  localparam logic [tccur_pkg::COL_W-1:0] COL_END  = tccur_pkg::COL_W'(COLS);
  localparam logic [tccur_pkg::ROW_W-1:0] LAST_ROW = tccur_pkg::ROW_W'(ROWS - 1);

  tccur_pkg::back_state_t state_r, state_nxt;
  tccur_pkg::cmd_t        cur_r, cur_nxt;
  logic [tccur_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tccur_pkg::ROW_W-1:0] row_r, row_nxt;

  logic                         out_valid_r;
  tccur_pkg::action_t           out_action_r;
  logic [tccur_pkg::COL_W-1:0]  out_col_r;
  logic [tccur_pkg::ROW_W-1:0]  out_row_r;
  logic [7:0]                   out_glyph_r;
  logic [31:0]                  out_colour_r;
  logic                         out_last_r;

  // Beat to load into the output register this cycle
  logic                         emit;
  tccur_pkg::action_t           emit_action;
  logic [tccur_pkg::COL_W-1:0]  emit_col;
  logic [tccur_pkg::ROW_W-1:0]  emit_row;
  logic [7:0]                   emit_glyph;
  logic [31:0]                  emit_colour;
  logic                         emit_last;

  logic                         slot_free;
  logic [tccur_pkg::COL_W-1:0]  col_inc;
  logic                         wrap;
  logic                         at_bottom;
  logic                         no_result;
  logic                         tab_stop;
  logic                         draw_ends;

  assign slot_free = !out_valid_r || out_ready;
  assign pop_ready = (state_r == tccur_pkg::ST_IDLE);
  assign col_inc   = col_r + tccur_pkg::COL_W'(1);
  assign wrap      = (col_inc == COL_END);
  assign at_bottom = (row_r == LAST_ROW);
  assign tab_stop  = (col_inc[tccur_pkg::TAB_BITS-1:0] == '0);
  // Kinds that emit nothing after a clear; a newline from row 0 never scrolls
  assign no_result = (cur_r.kind inside {tccur_pkg::CMD_CR, tccur_pkg::CMD_BS,
                                         tccur_pkg::CMD_DROP, tccur_pkg::CMD_NL});
  // Draw is the item's final beat unless a scroll or more tab padding follows
  assign draw_ends = !(wrap && at_bottom) &&
                     (wrap || (cur_r.kind == tccur_pkg::CMD_PRINT) || tab_stop);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tccur_pkg::ST_IDLE: begin
        if (pop_valid) begin
          if (pop_data.kind == tccur_pkg::CMD_CLEAR || pop_data.need_clear)
            state_nxt = tccur_pkg::ST_CLR;
          else
            state_nxt = tccur_pkg::ST_RUN;
        end
      end
      tccur_pkg::ST_CLR: begin
        if (slot_free) begin
          if (cur_r.kind == tccur_pkg::CMD_CLEAR) state_nxt = tccur_pkg::ST_IDLE;
          else state_nxt = tccur_pkg::ST_RUN;
        end
      end
      tccur_pkg::ST_RUN: begin
        case (cur_r.kind)
          tccur_pkg::CMD_NL: begin
            if (!at_bottom || slot_free) state_nxt = tccur_pkg::ST_IDLE;
          end
          tccur_pkg::CMD_PRINT, tccur_pkg::CMD_TAB: begin
            if (slot_free) begin
              if (wrap && at_bottom) state_nxt = tccur_pkg::ST_SCROLL;
              else if (draw_ends) state_nxt = tccur_pkg::ST_IDLE;
            end
          end
          default: state_nxt = tccur_pkg::ST_IDLE;
        endcase
      end
      tccur_pkg::ST_SCROLL: begin
        if (slot_free) state_nxt = tccur_pkg::ST_IDLE;
      end
      default: state_nxt = tccur_pkg::ST_IDLE;
    endcase
  end

  // Datapath and beat generation
  always_comb begin
    cur_nxt     = cur_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    emit        = 1'b0;
    emit_action = tccur_pkg::ACT_CLEAR;
    emit_col    = '0;
    emit_row    = '0;
    emit_glyph  = '0;
    emit_colour = '0;
    emit_last   = 1'b0;
    case (state_r)
      tccur_pkg::ST_IDLE: begin
        if (pop_valid) cur_nxt = pop_data;
      end
      tccur_pkg::ST_CLR: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_action = tccur_pkg::ACT_CLEAR;
          emit_last   = (cur_r.kind == tccur_pkg::CMD_CLEAR) || no_result;
          col_nxt     = '0;
          row_nxt     = '0;
        end
      end
      tccur_pkg::ST_RUN: begin
        case (cur_r.kind)
          tccur_pkg::CMD_NL: begin
            if (!at_bottom) begin
              col_nxt = '0;
              row_nxt = row_r + tccur_pkg::ROW_W'(1);
            end else if (slot_free) begin
              col_nxt     = '0;
              emit        = 1'b1;
              emit_action = tccur_pkg::ACT_SCROLL;
              emit_last   = 1'b1;
            end
          end
          tccur_pkg::CMD_CR: begin
            col_nxt = '0;
          end
          tccur_pkg::CMD_BS: begin
            if (col_r != '0) begin
              col_nxt = col_r - tccur_pkg::COL_W'(1);
            end else if (row_r != '0) begin
              row_nxt = row_r - tccur_pkg::ROW_W'(1);
              col_nxt = LAST_COL;
            end
          end
          tccur_pkg::CMD_PRINT, tccur_pkg::CMD_TAB: begin
            if (slot_free) begin
              emit        = 1'b1;
              emit_action = tccur_pkg::ACT_DRAW;
              emit_col    = col_r;
              emit_row    = row_r;
              emit_glyph  = (cur_r.kind == tccur_pkg::CMD_TAB) ? tccur_pkg::SPACE_CODE
                                                               : cur_r.char_code;
              emit_colour = fg_colour;
              emit_last   = draw_ends;
              if (wrap) begin
                col_nxt = '0;
                if (!at_bottom) row_nxt = row_r + tccur_pkg::ROW_W'(1);
              end else begin
                col_nxt = col_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end
      tccur_pkg::ST_SCROLL: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_action = tccur_pkg::ACT_SCROLL;
          emit_last   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccur_pkg::ST_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      out_action_r <= emit_action;
      out_col_r    <= emit_col;
      out_row_r    <= emit_row;
      out_glyph_r  <= emit_glyph;
      out_colour_r <= emit_colour;
      out_last_r   <= emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_action   = out_action_r;
  assign out_cell_col = out_col_r;
  assign out_cell_row = out_row_r;
  assign out_glyph    = out_glyph_r;
  assign out_colour   = out_colour_r;
  assign out_last     = out_last_r;

endmodule

// File: test/testbench.sv
// Testbench for the text console cursor engine: directed table, then random bursts.
`timescale 1ns / 1ps

module testbench;

  localparam int COLS        = 80;
  localparam int ROWS        = 30;
  localparam int SETTLE      = 24;   // cycles for a no-result beat to leave the back end
  localparam int HOLD_LEN    = 300;  // long receiver hold-off
  localparam int PHASE_ITEMS = 80;   // live input beats per random phase

  // One result beat
  typedef struct packed {
    tccur_pkg::action_t          action;
    logic [tccur_pkg::COL_W-1:0] col;
    logic [tccur_pkg::ROW_W-1:0] row;
    logic [7:0]                  glyph;
    logic [31:0]                 colour;
    logic                        last;
  } cell_t;

  // One directed row; typed rows carry the single result they expect, if any
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       typed;
    logic       has_cell;
    cell_t      exp_cell;
  } dir_row_t;

  localparam cell_t NO_CELL  = '0;
  localparam cell_t CLR_LAST = '{tccur_pkg::ACT_CLEAR, 7'd0, 5'd0, 8'h00, 32'h0, 1'b1};

  dir_row_t dir_tab [19] = '{
    // clear command before any character
    '{tccur_pkg::OP_CLEAR, 8'h00, 1'b1, 1'b1, CLR_LAST},
    // first character after reset clears even though it is dropped
    '{tccur_pkg::OP_PUT, 8'h01, 1'b1, 1'b1, CLR_LAST},
    '{tccur_pkg::OP_PUT, 8'h41, 1'b1, 1'b1,
      '{tccur_pkg::ACT_DRAW, 7'd0, 5'd0, 8'h41, tccur_pkg::DEFAULT_FG, 1'b1}},
    '{tccur_pkg::OP_PUT, 8'hFF, 1'b1, 1'b1,
      '{tccur_pkg::ACT_DRAW, 7'd1, 5'd0, 8'hFF, tccur_pkg::DEFAULT_FG, 1'b1}},
    // clear ignores the character byte
    '{tccur_pkg::OP_CLEAR, 8'hFF, 1'b1, 1'b1, CLR_LAST},
    // backspace at the top-left cell is ignored
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_BS, 1'b1, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, tccur_pkg::SPACE_CODE, 1'b1, 1'b1,
      '{tccur_pkg::ACT_DRAW, 7'd0, 5'd0, tccur_pkg::SPACE_CODE, tccur_pkg::DEFAULT_FG, 1'b1}},
    // partial tab from column 1, then a full tab from column 8
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_TAB, 1'b0, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_TAB, 1'b0, 1'b0, NO_CELL},
    // cursor-only moves
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_BS, 1'b1, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_CR, 1'b1, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_LF, 1'b1, 1'b0, NO_CELL},
    // backspace at column 0 goes to the last column of the row above
    '{tccur_pkg::OP_PUT, tccur_pkg::CHAR_BS, 1'b1, 1'b0, NO_CELL},
    // print at the last column, cursor wraps
    '{tccur_pkg::OP_PUT, 8'h7E, 1'b1, 1'b1,
      '{tccur_pkg::ACT_DRAW, 7'd79, 5'd0, 8'h7E, tccur_pkg::DEFAULT_FG, 1'b1}},
    // other control codes are dropped; 8'h80 and 8'h7F are printable and drawn
    '{tccur_pkg::OP_PUT, 8'h1F, 1'b1, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, 8'h00, 1'b1, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, 8'h0B, 1'b1, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, 8'h80, 1'b0, 1'b0, NO_CELL},
    '{tccur_pkg::OP_PUT, 8'h7F, 1'b0, 1'b0, NO_CELL}
  };

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        in_valid     = 1'b0;
  logic                        in_opcode    = 1'b0;
  logic [7:0]                  in_char_code = 8'h00;
  logic                        out_ready    = 1'b0;
  logic                        cfg_wr_en    = 1'b0;
  logic [31:0]                 cfg_wr_data  = 32'h0;
  logic                        in_ready;
  logic                        out_valid;
  logic [1:0]                  out_action;
  logic [tccur_pkg::COL_W-1:0] out_cell_col;
  logic [tccur_pkg::ROW_W-1:0] out_cell_row;
  logic [7:0]                  out_glyph;
  logic [31:0]                 out_colour;
  logic                        out_last;

  // Console model state
  int unsigned cur_col     = 0;
  int unsigned cur_row     = 0;
  bit          screen_live = 1'b0;
  logic [31:0] fg_now      = tccur_pkg::DEFAULT_FG;
  cell_t       step_cells [$];
  cell_t       pending_cells [$];

  int   errors      = 0;
  int   live_beats  = 0;
  int   in_idle_pct = 0;
  int   stall_pct   = 0;
  logic rx_hold     = 1'b0;
  event hold_kick;

  text_console_cursor_engine #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_action   (out_action),
    .out_cell_col (out_cell_col),
    .out_cell_row (out_cell_row),
    .out_glyph    (out_glyph),
    .out_colour   (out_colour),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Append one cell command to the current beat's results
  function automatic void queue_cell(tccur_pkg::action_t a, int unsigned c, int unsigned r,
                                     logic [7:0] g, logic [31:0] k);
    cell_t x;
    x.action = a;
    x.col    = c[tccur_pkg::COL_W-1:0];
    x.row    = r[tccur_pkg::ROW_W-1:0];
    x.glyph  = g;
    x.colour = k;
    x.last   = 1'b0;
    step_cells.push_back(x);
  endfunction

  // Move to the next row, scrolling at the bottom
  function automatic void line_feed();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      queue_cell(tccur_pkg::ACT_SCROLL, 0, 0, 8'h00, 32'h0);
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void draw_at_cursor(logic [7:0] g);
    queue_cell(tccur_pkg::ACT_DRAW, cur_col, cur_row, g, fg_now);
    cur_col++;
    if (cur_col >= COLS) line_feed();
  endfunction

  // Cell commands caused by one input beat
  function automatic void console_step(logic op, logic [7:0] ch);
    step_cells.delete();
    if (op == tccur_pkg::OP_CLEAR) begin
      queue_cell(tccur_pkg::ACT_CLEAR, 0, 0, 8'h00, 32'h0);
      cur_col = 0;
      cur_row = 0;
    end else begin
      if (!screen_live) begin
        queue_cell(tccur_pkg::ACT_CLEAR, 0, 0, 8'h00, 32'h0);
        cur_col     = 0;
        cur_row     = 0;
        screen_live = 1'b1;
      end
      case (ch)
        tccur_pkg::CHAR_LF: line_feed();
        tccur_pkg::CHAR_CR: cur_col = 0;
        tccur_pkg::CHAR_BS: begin
          if (cur_col > 0) begin
            cur_col--;
          end else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end
        end
        tccur_pkg::CHAR_TAB: begin
          draw_at_cursor(tccur_pkg::SPACE_CODE);
          while ((cur_col % (1 << tccur_pkg::TAB_BITS)) != 0)
            draw_at_cursor(tccur_pkg::SPACE_CODE);
        end
        default: begin
          if (ch >= tccur_pkg::SPACE_CODE) draw_at_cursor(ch);
        end
      endcase
    end
    if (step_cells.size() > 0) step_cells[step_cells.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Compare one accepted result beat with the oldest expectation
  task automatic check_cell();
    cell_t e;
    if (pending_cells.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    e = pending_cells.pop_front();
    if (out_action != e.action)
      report_mismatch($sformatf("action got %0d exp %0d", out_action, e.action));
    if (out_cell_col != e.col)
      report_mismatch($sformatf("cell_col got %0d exp %0d", out_cell_col, e.col));
    if (out_cell_row != e.row)
      report_mismatch($sformatf("cell_row got %0d exp %0d", out_cell_row, e.row));
    if (out_glyph != e.glyph)
      report_mismatch($sformatf("glyph got %02h exp %02h", out_glyph, e.glyph));
    if (out_colour != e.colour)
      report_mismatch($sformatf("colour got %08h exp %08h", out_colour, e.colour));
    if (out_last != e.last)
      report_mismatch($sformatf("last got %0b exp %0b", out_last, e.last));
  endtask

  // Receiver: check accepted beats, drive ready with random stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_cell();
    out_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off, counted here
  always begin
    @(hold_kick);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Offer one input beat; on acceptance run the model and queue its results
  task automatic send_beat(logic op, logic [7:0] ch, bit use_model);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_char_code <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    console_step(op, ch);
    if (use_model) begin
      foreach (step_cells[i]) pending_cells.push_back(step_cells[i]);
    end
    if (op == tccur_pkg::OP_CLEAR || ch >= tccur_pkg::SPACE_CODE ||
        ch == tccur_pkg::CHAR_LF || ch == tccur_pkg::CHAR_CR ||
        ch == tccur_pkg::CHAR_BS || ch == tccur_pkg::CHAR_TAB)
      live_beats++;
  endtask

  // Quiet the input and let every expected result and the back end drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_colour(logic [31:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fg_now = (v != 32'h0) ? v : tccur_pkg::DEFAULT_FG;
  endtask

  // One random burst: mostly well-formed console text, some noise
  task automatic run_burst();
    int kind;
    int tail;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // text line, long enough at times to wrap
      repeat ($urandom_range(1, 90))
        send_beat(tccur_pkg::OP_PUT, 8'($urandom_range(32, 255)), 1'b1);
      tail = $urandom_range(9);
      if (tail < 6) send_beat(tccur_pkg::OP_PUT, tccur_pkg::CHAR_LF, 1'b1);
      else if (tail < 8) send_beat(tccur_pkg::OP_PUT, tccur_pkg::CHAR_CR, 1'b1);
    end else if (kind < 55) begin
      // newline run, can reach the bottom row and scroll
      repeat ($urandom_range(5, 35)) send_beat(tccur_pkg::OP_PUT, tccur_pkg::CHAR_LF, 1'b1);
    end else if (kind < 67) begin
      // tabs between short words
      repeat ($urandom_range(1, 12)) begin
        send_beat(tccur_pkg::OP_PUT, tccur_pkg::CHAR_TAB, 1'b1);
        if ($urandom_range(1) == 1)
          send_beat(tccur_pkg::OP_PUT, 8'($urandom_range(33, 126)), 1'b1);
      end
    end else if (kind < 76) begin
      // backspace run, can cross row boundaries
      repeat ($urandom_range(1, 90)) send_beat(tccur_pkg::OP_PUT, tccur_pkg::CHAR_BS, 1'b1);
    end else if (kind < 80) begin
      send_beat(tccur_pkg::OP_CLEAR, 8'($urandom), 1'b1);
    end else begin
      // noise: any byte, now and then a clear
      repeat ($urandom_range(1, 6))
        send_beat(($urandom_range(9) == 0) ? tccur_pkg::OP_CLEAR : tccur_pkg::OP_PUT,
                  8'($urandom), 1'b1);
    end
  endtask

  // Main sequence
  initial begin
    logic [31:0] colour_set [4];
    int          in_pct [4];
    int          out_pct [4];
    bit          paused;
    colour_set = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, $urandom};
    in_pct     = '{0, 71, 0, 18};
    out_pct    = '{0, 0, 71, 18};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset colour
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].op, dir_tab[i].ch, !dir_tab[i].typed);
      if (dir_tab[i].typed && dir_tab[i].has_cell)
        pending_cells.push_back(dir_tab[i].exp_cell);
    end

    // random phases, one colour setting each
    for (int p = 0; p < 4; p++) begin
      write_colour(colour_set[p]);
      in_idle_pct = in_pct[p];
      stall_pct  <= out_pct[p];
      if (p == 0) -> hold_kick;
      live_beats = 0;
      paused     = 1'b0;
      while (live_beats < PHASE_ITEMS) begin
        run_burst();
        // sender pause until everything outstanding has come back
        if (p == 1 && !paused && live_beats >= PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (pending_cells.size() != 0);
          paused = 1'b1;
        end
      end
    end

    wait_idle();
    if (errors == 0) $display("PASS text_console_cursor_engine");
    else $display("FAIL text_console_cursor_engine");
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("FAIL text_console_cursor_engine");
    $finish;
  end

endmodule
